FILE: rtl/core/oat_pkg.sv
// Shared constants, codes and types of the ordered array table.
package oat_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned WordW    = 32;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned OpW      = 3;
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW     = (CntW > SlotW) ? CntW : SlotW;

  typedef enum logic [OpW-1:0] {
    OP_APPEND     = 3'd0,
    OP_INSERT_AT  = 3'd1,
    OP_DELETE_VAL = 3'd2,
    OP_DELETE_AT  = 3'd3,
    OP_FIND       = 3'd4,
    OP_DUMP       = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_BAD_POS   = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_APPEND,
    CM_INSERT,
    CM_REMOVE,
    CM_ROTATE
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e        mode;
    logic [CntW-1:0]   pos;
    logic [CntW-1:0]   count;
    logic [WordW-1:0]  key;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DUMP
  } state_e;

endpackage

FILE: rtl/core/ordered_array_table.sv
// Top level of the ordered array table: control sequencer over a chain of cells.
//
// The table keeps up to CAPACITY signed words in a row of cells, each cell
// holding one entry and trading words with its neighbors, plus a count of
// entries in use. A transaction is taken when start_i is high and busy_o is
// low. For append, insert at and delete at, every cell decides its own
// shift in the cycle the transaction is taken and the single result
// appears on the next cycle, while busy_o stays low so a new transaction
// can be taken at once. For delete value and find, the cells compare
// against the word and the match row is registered, then a lowest-match
// encoder picks the hit and, for delete value, the cells shift. Dump of an
// empty table gives a single result; otherwise the chain rotates by one
// each cycle and cell zero feeds one result per entry, so the table is back
// in order after the last entry. Each result is shown for exactly one
// cycle with done_o high; the receiver cannot stall it, so it must take
// every result as it comes. last_of_run_o marks the final result of a
// transaction. Opcodes 6 and 7 are ignored and give no result.
module ordered_array_table import oat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [SlotW-1:0]   slot_i,
  input  logic signed [WordW-1:0] word_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [SlotW-1:0]   found_slot_o,
  output logic signed [WordW-1:0] entry_word_o,
  output logic [SlotW-1:0]   fill_o,
  output logic               last_of_run_o
);

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     didx_q, didx_d;
  logic [CAPACITY-1:0] match_q, match_d;
  opcode_e             op_q, op_d;

  logic                res_valid_q, res_valid_d;
  status_e             status_q, status_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [WordW-1:0]    rword_q, rword_d;
  logic [SlotW-1:0]    fill_q, fill_d;
  logic                last_q, last_d;

  cell_cmd_t           cmd;
  logic [WordW-1:0]    cell_word [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] hit_onehot;
  logic [IdxW-1:0]     hit_idx;
  logic                full;
  logic                dump_last;

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WordW-1:0] lo_word, hi_word;
    if (g == 0) begin : g_lo_edge
      assign lo_word = '0;
    end else begin : g_lo
      assign lo_word = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_hi_edge
      assign hi_word = '0;
    end else begin : g_hi
      assign hi_word = cell_word[g+1];
    end
    oat_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .idx_i       (IdxW'(g)),
      .lo_word_i   (lo_word),
      .hi_word_i   (hi_word),
      .head_word_i (cell_word[0]),
      .entry_o     (cell_word[g]),
      .match_o     (match_vec[g])
    );
  end

  // Isolate the lowest match, then encode it with independent ORs
  assign hit_onehot = match_q & (~match_q + CAPACITY'(1));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_onehot[i]) hit_idx = hit_idx | IdxW'(i);
    end
  end

  assign full      = (count_q == CntW'(CAPACITY));
  assign dump_last = ((CntW'(didx_q) + CntW'(1)) == count_q);
  assign busy_o    = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    didx_d      = didx_q;
    match_d     = match_q;
    op_d        = op_q;
    cmd.mode    = CM_HOLD;
    cmd.pos     = '0;
    cmd.count   = count_q;
    cmd.key     = word_i;
    res_valid_d = 1'b0;
    status_d    = STAT_OK;
    slot_d      = '0;
    rword_d     = '0;
    last_d      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (opcode_e'(opcode_i))
            OP_APPEND: begin
              res_valid_d = 1'b1;
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                cmd.mode = CM_APPEND;
                count_d  = count_q + CntW'(1);
              end
            end
            OP_INSERT_AT: begin
              res_valid_d = 1'b1;
              // position check wins over the full check
              if (CmpW'(slot_i) > CmpW'(count_q)) begin
                status_d = STAT_BAD_POS;
              end else if (full) begin
                status_d = STAT_FULL;
              end else begin
                cmd.mode = CM_INSERT;
                cmd.pos  = CntW'(slot_i);
                count_d  = count_q + CntW'(1);
              end
            end
            OP_DELETE_VAL, OP_FIND: begin
              // capture the match row, resolve it next cycle
              match_d = match_vec;
              op_d    = opcode_e'(opcode_i);
              state_d = ST_SEARCH;
            end
            OP_DELETE_AT: begin
              res_valid_d = 1'b1;
              if (CmpW'(slot_i) >= CmpW'(count_q)) begin
                status_d = STAT_BAD_POS;
              end else begin
                cmd.mode = CM_REMOVE;
                cmd.pos  = CntW'(slot_i);
                count_d  = count_q - CntW'(1);
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
              end else begin
                didx_d  = '0;
                state_d = ST_DUMP;
              end
            end
            default: begin
              // unused opcode: drop it
            end
          endcase
        end
      end
      ST_SEARCH: begin
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
        if (match_q == '0) begin
          status_d = STAT_NOT_FOUND;
        end else if (op_q == OP_FIND) begin
          slot_d = SlotW'(hit_idx);
        end else begin
          cmd.mode = CM_REMOVE;
          cmd.pos  = CntW'(hit_idx);
          count_d  = count_q - CntW'(1);
        end
      end
      ST_DUMP: begin
        // emit the head, rotate the chain by one
        res_valid_d = 1'b1;
        slot_d      = SlotW'(didx_q);
        rword_d     = cell_word[0];
        last_d      = dump_last;
        cmd.mode    = CM_ROTATE;
        if (dump_last) begin
          state_d = ST_IDLE;
        end else begin
          didx_d = didx_q + IdxW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase

    fill_d = SlotW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q   <= didx_d;
    match_q  <= match_d;
    op_q     <= op_d;
    status_q <= status_d;
    slot_q   <= slot_d;
    rword_q  <= rword_d;
    fill_q   <= fill_d;
    last_q   <= last_d;
  end

  assign done_o        = res_valid_q;
  assign status_o      = status_q;
  assign found_slot_o  = slot_q;
  assign entry_word_o  = rword_q;
  assign fill_o        = fill_q;
  assign last_of_run_o = last_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_search_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |=> (state_q == ST_IDLE))
    else $error("search resolve did not finish in one cycle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FULL)) |-> (count_q == CntW'(CAPACITY)))
    else $error("full status reported on a table that is not full");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (count_q != '0))
    else $error("dump running on an empty table");

  a_dump_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> $stable(count_q))
    else $error("entry count changed during dump");

endmodule

FILE: rtl/core/oat_cell.sv
// One storage cell of the table chain: holds one entry, shifts and compares.
module oat_cell import oat_pkg::*; (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [IdxW-1:0]   idx_i,
  input  logic [WordW-1:0]  lo_word_i,
  input  logic [WordW-1:0]  hi_word_i,
  input  logic [WordW-1:0]  head_word_i,
  output logic [WordW-1:0]  entry_o,
  output logic              match_o
);

  logic [WordW-1:0] entry_q, entry_d;
  logic [CntW-1:0]  idx_c;
  logic [CntW-1:0]  idx_next;

  assign idx_c    = CntW'(idx_i);
  assign idx_next = idx_c + CntW'(1);

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.mode)
      CM_HOLD: entry_d = entry_q;
      CM_APPEND: begin
        if (idx_c == cmd_i.count) entry_d = cmd_i.key;
      end
      CM_INSERT: begin
        if (idx_c == cmd_i.pos) entry_d = cmd_i.key;
        else if (idx_c > cmd_i.pos) entry_d = lo_word_i;
      end
      CM_REMOVE: begin
        if (idx_c >= cmd_i.pos) entry_d = hi_word_i;
      end
      CM_ROTATE: begin
        // wrap the head into the last used cell, move the rest down
        if (idx_next == cmd_i.count) entry_d = head_word_i;
        else if (idx_next < cmd_i.count) entry_d = hi_word_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (idx_c < cmd_i.count) && (entry_q == cmd_i.key);

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the ordered array table.
module tb;
  import oat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes that the block ignores: no state change and no result.
  localparam logic [OpW-1:0] OP_RESERVED_LO = 3'd6;
  localparam logic [OpW-1:0] OP_RESERVED_HI = 3'd7;

  // Cycles with neither an input nor a result transaction before the run is called hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles to let pass after the last expected result, to catch stray results.
  localparam int unsigned DRAIN_SLACK = 8;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] found_slot;
    logic [WordW-1:0] entry_word;
    logic [SlotW-1:0] fill;
    logic             last;
  } table_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic [OpW-1:0]          opcode_i;
  logic [SlotW-1:0]        slot_i;
  logic signed [WordW-1:0] word_i;
  logic                    done_o;
  logic [1:0]              status_o;
  logic [SlotW-1:0]        found_slot_o;
  logic signed [WordW-1:0] entry_word_o;
  logic [SlotW-1:0]        fill_o;
  logic                    last_of_run_o;

  // Shadow copy of the table, kept in step with every accepted transaction.
  logic [WordW-1:0] table_mem [CAPACITY];
  int               table_fill;

  // Results still owed by the block, oldest first.
  table_result_t    pending_results [$];
  table_result_t    head_result;

  int               mismatch_count;
  int unsigned      stall_cycles;
  int unsigned      sender_idle_pct;
  logic [WordW-1:0] word_pool [8];

  ordered_array_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .slot_i        (slot_i),
    .word_i        (word_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_slot_o  (found_slot_o),
    .entry_word_o  (entry_word_o),
    .fill_o        (fill_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Queue one expected result behind the ones already owed.
  function automatic void add_expected(table_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // Any position the slot field can carry.
  function automatic logic [SlotW-1:0] any_slot();
    return SlotW'($urandom_range(0, 63));
  endfunction

  // Lowest index holding the word, or -1 when no entry matches.
  function automatic int first_index(logic [WordW-1:0] word);
    for (int i = 0; i < table_fill; i++) begin
      if (table_mem[i] == word) return i;
    end
    return -1;
  endfunction

  // Drop one entry and close the gap by shifting later entries down.
  function automatic void remove_entry(int pos);
    for (int i = pos; i + 1 < table_fill; i++) table_mem[i] = table_mem[i + 1];
    table_fill--;
  endfunction

  // Apply one accepted transaction to the shadow table and queue the results it owes.
  function automatic void predict_table_op(logic [OpW-1:0] op, logic [SlotW-1:0] slot,
                                           logic [WordW-1:0] word);
    table_result_t r;
    int            hit;
    r = '{status: STAT_OK, found_slot: '0, entry_word: '0, fill: '0, last: 1'b1};
    case (op)
      OP_APPEND: begin
        if (table_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          table_mem[table_fill] = word;
          table_fill++;
        end
      end
      OP_INSERT_AT: begin
        // The position check wins over the full check.
        if (slot > table_fill) begin
          r.status = STAT_BAD_POS;
        end else if (table_fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (int i = table_fill; i > slot; i--) table_mem[i] = table_mem[i - 1];
          table_mem[slot] = word;
          table_fill++;
        end
      end
      OP_DELETE_VAL: begin
        hit = first_index(word);
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else remove_entry(hit);
      end
      OP_DELETE_AT: begin
        if (slot >= table_fill) r.status = STAT_BAD_POS;
        else remove_entry(slot);
      end
      OP_FIND: begin
        hit = first_index(word);
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else r.found_slot = hit[SlotW-1:0];
      end
      OP_DUMP: begin
        // An empty table still answers with one result: all fields zero but last.
        if (table_fill == 0) begin
          add_expected(r);
          return;
        end
        for (int i = 0; i < table_fill; i++) begin
          r.found_slot = i[SlotW-1:0];
          r.entry_word = table_mem[i];
          r.fill       = table_fill[SlotW-1:0];
          r.last       = (i + 1 == table_fill);
          add_expected(r);
        end
        return;
      end
      default: return;
    endcase
    r.fill = table_fill[SlotW-1:0];
    add_expected(r);
  endfunction

  // Send one transaction: maybe idle first, then hold start_i until busy_o is low.
  // start_i stays high on return so back-to-back transactions need no extra step.
  task automatic send_op(input logic [OpW-1:0] op, input logic [SlotW-1:0] slot,
                         input logic [WordW-1:0] word);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i  <= 1'b1;
    opcode_i <= op;
    slot_i   <= slot;
    word_i   <= word;
    do @(posedge clk_i); while (busy_o);
    predict_table_op(op, slot, word);
  endtask

  // Hold the sender off until the block owes nothing.
  task automatic wait_for_drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void refresh_word_pool();
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;
    word_pool[2] = 32'h8000_0000;
    word_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom;
  endfunction

  // Favor a small pool so duplicates, hits and first-match rules show up often.
  function automatic logic [WordW-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20 && table_fill > 0) return table_mem[$urandom_range(0, table_fill - 1)];
    if (roll < 65) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [SlotW-1:0] pick_insert_slot();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return SlotW'($urandom_range(0, table_fill));
    if (roll < 90 && table_fill < CAPACITY)
      return SlotW'($urandom_range(table_fill + 1, CAPACITY));
    return any_slot();
  endfunction

  function automatic logic [SlotW-1:0] pick_delete_slot();
    if ($urandom_range(0, 99) < 80 && table_fill > 0)
      return SlotW'($urandom_range(0, table_fill - 1));
    return any_slot();
  endfunction

  // Empty table: every lookup misses, every position is bad, dump gives one empty result, ignored opcodes give none.
  task automatic test_empty_table();
    send_op(OP_DUMP, 6'd0, 32'd0);
    send_op(OP_FIND, 6'd0, 32'd5);
    send_op(OP_DELETE_VAL, 6'd0, 32'd5);
    send_op(OP_DELETE_AT, 6'd0, 32'd0);
    send_op(OP_INSERT_AT, 6'd1, 32'd7);
    send_op(OP_RESERVED_LO, 6'h3F, 32'hFFFF_FFFF);
    send_op(OP_RESERVED_HI, 6'd0, 32'd0);
  endtask

  // Extreme words, inserts at both ends, duplicates and first-match deletes.
  task automatic test_edge_values();
    send_op(OP_APPEND, 6'd0, 32'h8000_0000);
    send_op(OP_APPEND, 6'h3F, 32'h7FFF_FFFF);
    send_op(OP_INSERT_AT, 6'd0, 32'hFFFF_FFFF);
    send_op(OP_INSERT_AT, 6'd3, 32'h0000_0000);
    send_op(OP_INSERT_AT, 6'd1, 32'd12345);
    send_op(OP_APPEND, 6'd0, 32'hFFFF_FFFF);
    send_op(OP_FIND, 6'd0, 32'h7FFF_FFFF);
    send_op(OP_FIND, 6'd0, 32'hFFFF_FFFF);
    send_op(OP_FIND, 6'd0, 32'h1234_5678);
    send_op(OP_DUMP, 6'd0, 32'd0);
    send_op(OP_DELETE_VAL, 6'd0, 32'hFFFF_FFFF);
    send_op(OP_DELETE_AT, 6'd0, 32'd0);
    send_op(OP_DELETE_AT, 6'd4, 32'd0);
    send_op(OP_INSERT_AT, 6'h3F, 32'd1);
    send_op(OP_DUMP, 6'd0, 32'd0);
  endtask

  // Fill to capacity, then hit the full and bad-position paths and dump the lot.
  task automatic test_full_table();
    refresh_word_pool();
    while (table_fill < CAPACITY) begin
      if ($urandom_range(0, 1)) send_op(OP_APPEND, 6'd0, pick_word());
      else send_op(OP_INSERT_AT, SlotW'($urandom_range(0, table_fill)), pick_word());
    end
    send_op(OP_APPEND, 6'd0, 32'd99);
    send_op(OP_INSERT_AT, SlotW'(CAPACITY), 32'd99);
    send_op(OP_INSERT_AT, SlotW'(CAPACITY + 1), 32'd99);
    send_op(OP_FIND, 6'd0, table_mem[CAPACITY - 1]);
    send_op(OP_DUMP, 6'd0, 32'd0);
    send_op(OP_DELETE_AT, SlotW'(CAPACITY), 32'd0);
    send_op(OP_DELETE_AT, SlotW'(CAPACITY - 1), 32'd0);
    send_op(OP_DUMP, 6'd0, 32'd0);
  endtask

  // Random mix that swings the table between empty and full.
  task automatic test_random_traffic(input int item_target, input int unsigned idle_pct);
    int          sent;
    bit          grow;
    int unsigned roll;
    sender_idle_pct = idle_pct;
    refresh_word_pool();
    wait_for_drain();
    sent = 0;
    grow = (table_fill < CAPACITY / 2);
    while (sent < item_target) begin
      if (table_fill == 0) grow = 1'b1;
      else if (table_fill == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if ($urandom_range(0, 49) == 0) grow = !grow;
      // Now and then let the block run dry before the next transaction.
      if ($urandom_range(0, 24) == 0) wait_for_drain();
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // Ignored opcodes: exercise them but do not count them.
        send_op($urandom_range(0, 1) ? OP_RESERVED_HI : OP_RESERVED_LO,
                any_slot(), $urandom);
      end else begin
        roll = $urandom_range(0, 99);
        if (grow) begin
          if (roll < 35) send_op(OP_APPEND, any_slot(), pick_word());
          else if (roll < 70) send_op(OP_INSERT_AT, pick_insert_slot(), pick_word());
          else if (roll < 75) send_op(OP_DELETE_VAL, any_slot(), pick_word());
          else if (roll < 80) send_op(OP_DELETE_AT, pick_delete_slot(), $urandom);
          else if (roll < 95) send_op(OP_FIND, any_slot(), pick_word());
          else send_op(OP_DUMP, any_slot(), $urandom);
        end else begin
          if (roll < 10) send_op(OP_APPEND, any_slot(), pick_word());
          else if (roll < 20) send_op(OP_INSERT_AT, pick_insert_slot(), pick_word());
          else if (roll < 45) send_op(OP_DELETE_VAL, any_slot(), pick_word());
          else if (roll < 75) send_op(OP_DELETE_AT, pick_delete_slot(), $urandom);
          else if (roll < 95) send_op(OP_FIND, any_slot(), pick_word());
          else send_op(OP_DUMP, any_slot(), $urandom);
        end
        sent++;
      end
    end
  endtask

  // Take every result in the cycle it is shown and compare it with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, entry_word", entry_word_o, 32'd0);
      end else begin
        head_result = pending_results.pop_front();
        if (status_o !== head_result.status)
          report_mismatch("status", 32'(status_o), 32'(head_result.status));
        if (found_slot_o !== head_result.found_slot)
          report_mismatch("found_slot", 32'(found_slot_o), 32'(head_result.found_slot));
        if (entry_word_o !== head_result.entry_word)
          report_mismatch("entry_word", entry_word_o, head_result.entry_word);
        if (fill_o !== head_result.fill)
          report_mismatch("fill", 32'(fill_o), 32'(head_result.fill));
        if (last_of_run_o !== head_result.last)
          report_mismatch("last_of_run", 32'(last_of_run_o), 32'(head_result.last));
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", stall_cycles);
      $display("ordered_array_table test failed");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    start_i         <= 1'b0;
    opcode_i        <= OP_APPEND;
    slot_i          <= '0;
    word_i          <= '0;
    table_fill      = 0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_edge_values();
    test_full_table();
    // Sender idles lightly, then heavily, then not at all.
    test_random_traffic(80, 21);
    test_random_traffic(70, 74);
    test_random_traffic(60, 0);

    // Drain, then give the block time to show any stray result.
    wait_for_drain();
    repeat (DRAIN_SLACK) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered, count", pending_results.size(), 32'd0);

    if (mismatch_count == 0) begin
      $display("ordered_array_table test passed");
    end else begin
      $display("ordered_array_table test failed");
    end
    $finish;
  end

endmodule
